// ===== hdl/gn3_pkg.sv =====
// Shared types, constants and helpers for the 3D gradient noise block.
package gn3_pkg;
	localparam int TABLE_SIZE_DEF = 256;
	localparam int FRAC_BITS_DEF = 16;
	localparam int IDX_W = 8;
	localparam int COORD_W = 24;
	localparam int OUT_W = 17;
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	typedef struct packed {
		logic                      command;
		logic [IDX_W-1:0]          table_index;
		logic [IDX_W-1:0]          table_value;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
	} req_t;

	// Gradient dot product for one corner; operands carry one integer bit plus sign.
	function automatic logic signed [27:0] grad_dot(input logic [3:0] h,
		input logic signed [27:0] x, input logic signed [27:0] y,
		input logic signed [27:0] z);
		logic signed [27:0] u;
		logic signed [27:0] v;
		begin
			u = (h < 4'd8) ? x : y;
			v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
			grad_dot = (h[0] ? -u : u) + (h[1] ? -v : v);
		end
	endfunction
endpackage

// ===== hdl/gn3_if.sv =====
// Valid/ready channel carrying one payload.
interface gn3_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/gradient_noise_3d.sv =====
// Top level of the 3D gradient noise pipeline.
// One request per cycle unless the output stalls: a write request loads one permutation byte and
// gives no result; an evaluate request gives one noise value after three dependent table lookups
// through dual-read RAMs and the blend tree.
// Results leave in request order; a stall on the output freezes the whole pipeline.
// Table entries must be written before any evaluation reads them.
module gradient_noise_3d #(
	parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	gn3_if.sink   req,
	gn3_if.source rsp
);
	import gn3_pkg::*;
	localparam int TABLE_SIZE = TABLE_SIZE_DEF;
	localparam int AW = $clog2(TABLE_SIZE);
	localparam int FB = FRAC_BITS;
	localparam int GW = FB + 12;
	localparam int NST = 11;

	req_t r;
	logic en;
	logic [NST-1:0] vld_q;
	logic [OUT_W-1:0] out_q;
	assign r = req.data;
	assign en = !rsp.valid || rsp.ready || !vld_q[NST-1];
	assign req.ready = en;

	logic wr;
	assign wr = req.valid && en && r.command == CMD_WRITE;
	logic ev;
	assign ev = req.valid && en && r.command == CMD_EVAL;

	// Table writes reach the later table copies in step with the lookups.
	logic [4:1] wv_d;
	logic [AW-1:0] wa_d [1:4];
	logic [7:0] wd_d [1:4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wv_d <= '0;
		else if (en)
			wv_d <= {wv_d[3:1], wr};
	end
	always_ff @(posedge clk) begin
		if (en) begin
			wa_d[1] <= AW'(r.table_index);
			wd_d[1] <= r.table_value;
			for (int i = 2; i <= 4; i++) begin
				wa_d[i] <= wa_d[i-1];
				wd_d[i] <= wd_d[i-1];
			end
		end
	end
	logic we2, we4;
	assign we2 = wv_d[2] && en;
	assign we4 = wv_d[4] && en;

	// Stage 1: split coordinates.
	logic [AW-1:0] cx_s1, cy_s1, cz_s1;
	logic [FB-1:0] fx_s1, fy_s1, fz_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1 <= AW'(r.coord_x >>> FB);
			cy_s1 <= AW'(r.coord_y >>> FB);
			cz_s1 <= AW'(r.coord_z >>> FB);
			fx_s1 <= r.coord_x[FB-1:0];
			fy_s1 <= r.coord_y[FB-1:0];
			fz_s1 <= r.coord_z[FB-1:0];
		end
	end

	// Fades finish at stage 5.
	logic [FB:0] u_f, v_f, w_f;
	gn3_fade #(.FRAC_BITS(FB)) u_fx (.clk, .en, .t(fx_s1), .f(u_f));
	gn3_fade #(.FRAC_BITS(FB)) u_fy (.clk, .en, .t(fy_s1), .f(v_f));
	gn3_fade #(.FRAC_BITS(FB)) u_fz (.clk, .en, .t(fz_s1), .f(w_f));

	// Coordinate delay line (stages 2..8).
	logic [AW-1:0] cy_d [2:3];
	logic [AW-1:0] cz_d [2:5];
	logic [3*FB-1:0] fr_d [2:8];
	always_ff @(posedge clk) begin
		if (en) begin
			cy_d[2] <= cy_s1; cy_d[3] <= cy_d[2];
			cz_d[2] <= cz_s1;
			for (int i = 3; i <= 5; i++) cz_d[i] <= cz_d[i-1];
			fr_d[2] <= {fx_s1, fy_s1, fz_s1};
			for (int i = 3; i <= 8; i++) fr_d[i] <= fr_d[i-1];
		end
	end

	// Hash level 1: P[cx], P[cx+1] -> stage 2 data.
	logic [7:0] pa_s2, pb_s2;
	gn3_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram1 (.clk, .we(wr),
		.waddr(AW'(r.table_index)), .wdata(r.table_value), .re(en),
		.raddr_a(cx_s1), .raddr_b(cx_s1 + AW'(1)), .rdata_a(pa_s2), .rdata_b(pb_s2));
	logic [AW-1:0] a_s3, b_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= AW'(pa_s2) + cy_d[2];
			b_s3 <= AW'(pb_s2) + cy_d[2];
		end
	end

	// Hash level 2: P[a], P[a+1], P[b], P[b+1] -> stage 4.
	logic [7:0] paa_s4, pab_s4, pba_s4, pbb_s4;
	gn3_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram2a (.clk, .we(we2),
		.waddr(wa_d[2]), .wdata(wd_d[2]), .re(en),
		.raddr_a(a_s3), .raddr_b(a_s3 + AW'(1)), .rdata_a(paa_s4), .rdata_b(pab_s4));
	gn3_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram2b (.clk, .we(we2),
		.waddr(wa_d[2]), .wdata(wd_d[2]), .re(en),
		.raddr_a(b_s3), .raddr_b(b_s3 + AW'(1)), .rdata_a(pba_s4), .rdata_b(pbb_s4));
	logic [AW-1:0] h2_s5 [4];
	always_ff @(posedge clk) begin
		if (en) begin
			h2_s5[0] <= AW'(paa_s4) + cz_d[4];
			h2_s5[1] <= AW'(pba_s4) + cz_d[4];
			h2_s5[2] <= AW'(pab_s4) + cz_d[4];
			h2_s5[3] <= AW'(pbb_s4) + cz_d[4];
		end
	end

	// Hash level 3: eight corner hashes -> stage 6.
	logic [7:0] hc_s6 [8];
	for (genvar g = 0; g < 4; g++) begin : g_h3
		gn3_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram3 (.clk, .we(we4),
			.waddr(wa_d[4]), .wdata(wd_d[4]), .re(en),
			.raddr_a(h2_s5[g]), .raddr_b(h2_s5[g] + AW'(1)),
			.rdata_a(hc_s6[g]), .rdata_b(hc_s6[g+4]));
	end

	// Fade delay to blend stages.
	logic [FB:0] u_d [6:7];
	logic [FB:0] v_d [6:8];
	logic [FB:0] w_d [6:9];
	always_ff @(posedge clk) begin
		if (en) begin
			u_d[6] <= u_f; u_d[7] <= u_d[6];
			v_d[6] <= v_f; v_d[7] <= v_d[6]; v_d[8] <= v_d[7];
			w_d[6] <= w_f;
			for (int i = 7; i <= 9; i++) w_d[i] <= w_d[i-1];
		end
	end

	// Stage 7: gradients.
	logic signed [27:0] gx0, gy0, gz0, gx1, gy1, gz1;
	assign gx0 = 28'(signed'({1'b0, fr_d[6][3*FB-1:2*FB]})) <<< (24 - FB);
	assign gy0 = 28'(signed'({1'b0, fr_d[6][2*FB-1:FB]})) <<< (24 - FB);
	assign gz0 = 28'(signed'({1'b0, fr_d[6][FB-1:0]})) <<< (24 - FB);
	assign gx1 = gx0 - (28'sd1 <<< 24);
	assign gy1 = gy0 - (28'sd1 <<< 24);
	assign gz1 = gz0 - (28'sd1 <<< 24);
	logic signed [GW-1:0] gr_s7 [8];
	always_ff @(posedge clk) begin
		if (en) begin
			gr_s7[0] <= GW'(grad_dot(hc_s6[0][3:0], gx0, gy0, gz0) >>> (24 - FB));
			gr_s7[1] <= GW'(grad_dot(hc_s6[1][3:0], gx1, gy0, gz0) >>> (24 - FB));
			gr_s7[2] <= GW'(grad_dot(hc_s6[2][3:0], gx0, gy1, gz0) >>> (24 - FB));
			gr_s7[3] <= GW'(grad_dot(hc_s6[3][3:0], gx1, gy1, gz0) >>> (24 - FB));
			gr_s7[4] <= GW'(grad_dot(hc_s6[4][3:0], gx0, gy0, gz1) >>> (24 - FB));
			gr_s7[5] <= GW'(grad_dot(hc_s6[5][3:0], gx1, gy0, gz1) >>> (24 - FB));
			gr_s7[6] <= GW'(grad_dot(hc_s6[6][3:0], gx0, gy1, gz1) >>> (24 - FB));
			gr_s7[7] <= GW'(grad_dot(hc_s6[7][3:0], gx1, gy1, gz1) >>> (24 - FB));
		end
	end

	// Blend tree: stages 8, 9, 10.
	logic signed [GW-1:0] lx_s8 [4];
	logic signed [GW-1:0] ly_s9 [2];
	logic signed [GW-1:0] res_s10;
	for (genvar g = 0; g < 4; g++) begin : g_lx
		gn3_lerp #(.FRAC_BITS(FB)) u_l (.clk, .en, .t(u_d[7]),
			.a(gr_s7[2*g]), .b(gr_s7[2*g+1]), .y(lx_s8[g]));
	end
	for (genvar g = 0; g < 2; g++) begin : g_ly
		gn3_lerp #(.FRAC_BITS(FB)) u_l (.clk, .en, .t(v_d[8]),
			.a(lx_s8[2*g]), .b(lx_s8[2*g+1]), .y(ly_s9[g]));
	end
	gn3_lerp #(.FRAC_BITS(FB)) u_lz (.clk, .en, .t(w_d[9]),
		.a(ly_s9[0]), .b(ly_s9[1]), .y(res_s10));

	// Stage 11: output mapping.
	logic signed [GW:0] ov;
	logic signed [GW:0] sc;
	always_comb begin
		ov = (GW+1)'(res_s10) + (GW+1)'(signed'(1 << FB));
		if (ov < 0)
			ov = '0;
		if (FB + 1 >= 16)
			sc = ov >>> (FB + 1 - 16);
		else
			sc = ov <<< (16 - FB - 1);
		if (sc > (GW+1)'(65536))
			sc = (GW+1)'(65536);
	end
	always_ff @(posedge clk) begin
		if (en)
			out_q <= OUT_W'(sc);
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[NST-2:0], ev};
	end

	logic unused_d;
	assign unused_d = ^{fr_d[7], fr_d[8], cy_d[3], cz_d[5], cz_d[3]};
	assign rsp.valid = vld_q[NST-1];
	assign rsp.data = out_q;
endmodule

// ===== hdl/gn3_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
module gn3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end
endmodule

// ===== hdl/gn3_fade.sv =====
// Fade curve 6t^5-15t^4+10t^3 over four pipeline stages with enable.
module gn3_fade #(
	parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [FRAC_BITS-1:0] t,
	output logic [FRAC_BITS:0]   f
);
	localparam int FB = FRAC_BITS;
	logic [FB-1:0] t_s1;
	logic [FB:0]   tt_s1, t3_s2, f_s3;
	logic signed [FB+5:0] in_s2;
	logic [2*FB+1:0] p_tt, p_t3;
	logic signed [2*FB+7:0] p_in, p_f;
	logic signed [FB+5:0] lin;

	assign p_tt = (2*FB+2)'(t) * (2*FB+2)'(t);
	assign lin = (FB+6)'(signed'({1'b0, t})) * (FB+6)'(6)
		- (FB+6)'(signed'(15 << FB));

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= t;
			tt_s1 <= (FB+1)'(p_tt >> FB);
			t3_s2 <= (FB+1)'(p_t3 >> FB);
			in_s2 <= (FB+6)'(p_in >>> FB) + (FB+6)'(signed'(10 << FB));
			f_s3 <= (FB+1)'(p_f >>> FB);
			f <= f_s3;
		end
	end

	logic signed [FB+5:0] lin_s1;
	always_ff @(posedge clk) begin
		if (en)
			lin_s1 <= lin;
	end
	assign p_t3 = (2*FB+2)'(tt_s1) * (2*FB+2)'(t_s1);
	assign p_in = (2*FB+8)'(signed'({1'b0, t_s1})) * (2*FB+8)'(lin_s1);
	assign p_f = (2*FB+8)'(signed'({1'b0, t3_s2})) * (2*FB+8)'(in_s2);
endmodule

// ===== hdl/gn3_lerp.sv =====
// Registered blend a + t*(b-a) with floor truncation.
module gn3_lerp #(
	parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [FRAC_BITS:0]         t,
	input  logic signed [FRAC_BITS+11:0] a,
	input  logic signed [FRAC_BITS+11:0] b,
	output logic signed [FRAC_BITS+11:0] y
);
	localparam int W = FRAC_BITS + 12;
	logic signed [2*W:0] p;
	assign p = (2*W+1)'(signed'({1'b0, t})) * (2*W+1)'(b - a);
	always_ff @(posedge clk) begin
		if (en)
			y <= a + W'(p >>> FRAC_BITS);
	end
endmodule

// ===== hdl/gn3_checker.sv =====
// Port-level checker for the gradient noise block, bound to the top level.
module gn3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [16:0] rsp_data
);
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data <= 17'd65536) else $error("noise out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result dropped under stall");
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready) else $error("input blocked while output empty");
	a_noreq: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(arst_n) |-> !rsp_valid) else $error("result after reset");
endmodule

bind gradient_noise_3d gn3_checker u_chk (.clk, .arst_n,
	.req_valid(req.valid), .req_ready(req.ready), .rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready), .rsp_data(rsp.data));

// ===== tb/gn3_checker.sv =====
// Checker that predicts noise values from observed requests and compares responses.
module tb_gn3_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  gn3_pkg::req_t req_data,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  logic [gn3_pkg::OUT_W-1:0] rsp_data,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import gn3_pkg::*;

	logic [7:0] perm_table [256];
	logic [OUT_W-1:0] noise_queue [$];

	function automatic longint floor16(longint v);
		return v >>> 16;
	endfunction

	function automatic longint fxmul(longint a, longint b);
		return floor16(a * b);
	endfunction

	function automatic longint fade(longint t);
		longint t3;
		longint inner;
		t3 = fxmul(fxmul(t, t), t);
		inner = fxmul(t, t * 6 - 15 * 65536) + 10 * 65536;
		return fxmul(t3, inner);
	endfunction

	function automatic longint lerp(longint t, longint a, longint b);
		return a + fxmul(t, b - a);
	endfunction

	function automatic longint gdot(int h, longint x, longint y, longint z);
		longint u;
		longint v;
		h = h & 15;
		u = (h < 8) ? x : y;
		v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
		return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
	endfunction

	function automatic int pt(int idx);
		return int'(perm_table[idx & 255]);
	endfunction

	function automatic logic [OUT_W-1:0] noise_at(req_t r);
		longint x, y, z, u, v, w, x1, y1, z1, lo, hi, res;
		int cx, cy, cz, a, aa, ab, b, ba, bb;
		x = longint'(r.coord_x);
		y = longint'(r.coord_y);
		z = longint'(r.coord_z);
		cx = int'(floor16(x)) & 255;
		cy = int'(floor16(y)) & 255;
		cz = int'(floor16(z)) & 255;
		x = x & 65535;
		y = y & 65535;
		z = z & 65535;
		u = fade(x);
		v = fade(y);
		w = fade(z);
		a = pt(cx) + cy;
		aa = pt(a) + cz;
		ab = pt(a + 1) + cz;
		b = pt(cx + 1) + cy;
		ba = pt(b) + cz;
		bb = pt(b + 1) + cz;
		x1 = x - 65536;
		y1 = y - 65536;
		z1 = z - 65536;
		lo = lerp(v, lerp(u, gdot(pt(aa), x, y, z), gdot(pt(ba), x1, y, z)),
			lerp(u, gdot(pt(ab), x, y1, z), gdot(pt(bb), x1, y1, z)));
		hi = lerp(v, lerp(u, gdot(pt(aa + 1), x, y, z1), gdot(pt(ba + 1), x1, y, z1)),
			lerp(u, gdot(pt(ab + 1), x, y1, z1), gdot(pt(bb + 1), x1, y1, z1)));
		res = lerp(w, lo, hi) + 65536;
		if (res < 0) res = 0;
		res = res >>> 1;
		if (res > 65536) res = 65536;
		return res[OUT_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [OUT_W-1:0] expected_noise;
		if (!arst_n) begin
			errors <= 0;
			pending <= 0;
			noise_queue.delete();
		end else begin
			if (req_valid && req_ready) begin
				if (req_data.command == CMD_WRITE)
					perm_table[req_data.table_index] = req_data.table_value;
				else
					noise_queue.push_back(noise_at(req_data));
			end
			if (rsp_valid && rsp_ready) begin
				if (noise_queue.size() == 0) begin
					$error("noise_value: unexpected response %0d", rsp_data);
					errors <= errors + 1;
				end else begin
					expected_noise = noise_queue.pop_front();
					if (expected_noise !== rsp_data) begin
						$error("noise_value: expected %0d, actual %0d", expected_noise, rsp_data);
						errors <= errors + 1;
					end
				end
			end
			pending <= noise_queue.size();
		end
	end
endmodule

// ===== tb/tb_gradient_noise_3d.sv =====
// Testbench top: drives table loads and noise evaluations and reports the verdict.
module tb_gradient_noise_3d;
	timeunit 1ns;
	timeprecision 1ps;
	import gn3_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors;
	int pending;
	longint cycles = 0;
	logic long_hold = 1'b0;

	gn3_if #(.W($bits(req_t))) req ();
	gn3_if #(.W(OUT_W)) rsp ();

	gradient_noise_3d dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	tb_gn3_checker chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req.valid), .req_ready(req.ready), .req_data(req_t'(req.data)),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
		.errors(errors), .pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (1000) @(negedge clk);
		long_hold = 1'b1;
		repeat (300) @(negedge clk);
		long_hold = 1'b0;
	end

	always @(negedge clk) begin
		int phase;
		phase = int'(cycles % 64);
		if (long_hold)
			rsp.ready <= 1'b0;
		else if (phase < 16)
			rsp.ready <= 1'b1;
		else
			rsp.ready <= ($urandom_range(0, 3) != 0);
	end

	task automatic send(req_t r);
		req.data <= r;
		req.valid <= 1'b1;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic pause_maybe();
		if ($urandom_range(0, 5) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	function automatic req_t eval_at(logic [23:0] x, logic [23:0] y, logic [23:0] z);
		req_t r;
		r = '0;
		r.command = CMD_EVAL;
		r.coord_x = x;
		r.coord_y = y;
		r.coord_z = z;
		r.table_index = 8'($urandom);
		r.table_value = 8'($urandom);
		return r;
	endfunction

	initial begin
		req_t r;
		int k;
		req.valid = 1'b0;
		req.data = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (k = 0; k < 256; k++) begin
			r = '0;
			r.command = CMD_WRITE;
			r.table_index = 8'(k);
			r.table_value = 8'($urandom);
			r.coord_x = 24'($urandom);
			r.coord_y = 24'($urandom);
			r.coord_z = 24'($urandom);
			send(r);
			pause_maybe();
		end
		send(eval_at(24'h000000, 24'h000000, 24'h000000));
		send(eval_at(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
		send(eval_at(24'h800000, 24'h800000, 24'h800000));
		send(eval_at(24'hFFFFFF, 24'h000001, 24'h00FFFF));
		send(eval_at(24'h008000, 24'h008000, 24'h008000));
		send(eval_at(24'hFF0000, 24'h010000, 24'h7F0000));
		send(eval_at(24'h80FFFF, 24'h00FFFF, 24'hFFFF00));
		for (k = 0; k < 1150; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				r = '0;
				r.command = CMD_WRITE;
				r.table_index = 8'($urandom);
				r.table_value = 8'($urandom);
				r.coord_x = 24'($urandom);
				r.coord_y = 24'($urandom);
				r.coord_z = 24'($urandom);
			end else if ($urandom_range(0, 3) == 0)
				r = eval_at($urandom_range(0, 3) == 0 ? 24'h800000 : 24'($urandom),
					{8'($urandom_range(0, 255)), 16'hFFFF}, {8'h00, 16'($urandom)});
			else
				r = eval_at(24'($urandom), 24'($urandom), 24'($urandom));
			send(r);
			if (k % 200 > 100) pause_maybe();
		end
		req.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
